/* rtl/core/quantum_gate_basis_entry_update_top_macros.svh */
// Assertion helpers for the files that check their own logic.
`ifndef QUANTUM_GATE_BASIS_ENTRY_UPDATE_TOP_MACROS_SVH
`define QUANTUM_GATE_BASIS_ENTRY_UPDATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QGBEU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QGBEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/qgbeu_pkg.sv */
`default_nettype none

package qgbeu_pkg;

   localparam int STATE_BITS = 64;
   localparam int MASK_BITS  = 64;
   localparam int AMP_BITS   = 32;
   localparam int FRAC_BITS  = AMP_BITS - 2;
   // One extra bit so that the negated phase factors stay exact.
   localparam int FACT_BITS  = AMP_BITS + 1;
   localparam int PROD_BITS  = AMP_BITS + FACT_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int OP_BITS    = 4;
   localparam int TGT_BITS   = 6;
   localparam int SWW_BITS   = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [SWW_BITS-1:0] SWAP_MAX = SWW_BITS'(32);

   localparam logic signed [FACT_BITS-1:0] FACT_ONE     = FACT_BITS'(64'd1 << FRAC_BITS);
   localparam logic signed [FACT_BITS-1:0] FACT_NEG_ONE = -FACT_ONE;
   localparam logic signed [AMP_BITS-1:0]  PHASE_ONE    = AMP_BITS'(64'd1 << FRAC_BITS);

   localparam logic signed [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
   localparam logic signed [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);

   typedef enum logic [OP_BITS-1:0] {
      GATE_MCNOT       = 4'd0,
      GATE_X           = 4'd1,
      GATE_Y           = 4'd2,
      GATE_Z           = 4'd3,
      GATE_ROT_Z       = 4'd4,
      GATE_PHASE_SCALE = 4'd5,
      GATE_PHASE_KICK  = 4'd6,
      GATE_COND_PHASE  = 4'd7,
      GATE_COND_SHIFT  = 4'd8,
      GATE_SWAP        = 4'd9
   } gate_op_type;

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_GATE_OP      = 3'd0,
      REG_CONTROL_MASK = 3'd1,
      REG_TARGET_BIT   = 3'd2,
      REG_PHASE_REAL   = 3'd3,
      REG_PHASE_IMAG   = 3'd4,
      REG_SWAP_WIDTH   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [OP_BITS-1:0]          gate_op;
      logic [MASK_BITS-1:0]        control_mask;
      logic [TGT_BITS-1:0]         target_bit;
      logic signed [AMP_BITS-1:0]  phase_real;
      logic signed [AMP_BITS-1:0]  phase_imag;
      logic [SWW_BITS-1:0]         swap_width;
   } cfg_type;

   typedef struct packed {
      logic [STATE_BITS-1:0]        basis;
      logic signed [FACT_BITS-1:0]  fact_re;
      logic signed [FACT_BITS-1:0]  fact_im;
      logic                         mul;
   } dec_type;

   typedef struct packed {
      logic [63:0]         basis_in;
      logic signed [31:0]  amp_re_in;
      logic signed [31:0]  amp_im_in;
      logic                last_in;
   } req_payload_type;

   typedef struct packed {
      logic [63:0]         basis_out;
      logic signed [31:0]  amp_re_out;
      logic signed [31:0]  amp_im_out;
      logic                last_out;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/core/qgbeu_gate_decode.sv */
`default_nettype none

module qgbeu_gate_decode (
   input  wire logic [63:0]            basis_in,
   input  wire qgbeu_pkg::cfg_type     cfg,
   output qgbeu_pkg::dec_type          dec
);

   logic [qgbeu_pkg::STATE_BITS-1:0]        s;
   logic [qgbeu_pkg::STATE_BITS-1:0]        tmask;
   logic [qgbeu_pkg::STATE_BITS-1:0]        flipped;
   logic [qgbeu_pkg::STATE_BITS-1:0]        fmask;
   logic [qgbeu_pkg::STATE_BITS-1:0]        low_field;
   logic [qgbeu_pkg::STATE_BITS-1:0]        high_field;
   logic [qgbeu_pkg::STATE_BITS-1:0]        swapped;
   logic [qgbeu_pkg::SWW_BITS-1:0]          sw;
   logic                                    ctl;
   logic                                    hit;
   logic signed [qgbeu_pkg::FACT_BITS-1:0]  zr;
   logic signed [qgbeu_pkg::FACT_BITS-1:0]  zi;
   logic signed [qgbeu_pkg::FACT_BITS-1:0]  zi_sel;

   always_comb begin
      s       = qgbeu_pkg::STATE_BITS'(basis_in);
      // The six-bit target index always selects one bit of the 64-bit state.
      tmask   = qgbeu_pkg::STATE_BITS'(1) << cfg.target_bit;
      flipped = s ^ tmask;
      hit     = |(s & tmask);
      ctl     = (qgbeu_pkg::MASK_BITS'(s) & cfg.control_mask) == cfg.control_mask;

      zr      = qgbeu_pkg::FACT_BITS'(cfg.phase_real);
      zi      = qgbeu_pkg::FACT_BITS'(cfg.phase_imag);
      // The conjugate is used when the target bit is clear.
      zi_sel  = hit ? zi : -zi;

      sw         = (cfg.swap_width > qgbeu_pkg::SWAP_MAX) ? qgbeu_pkg::SWAP_MAX
                                                          : cfg.swap_width;
      fmask      = ~({qgbeu_pkg::STATE_BITS{1'b1}} << sw);
      low_field  = s & fmask;
      high_field = (s >> sw) & fmask;
      swapped    = (s & ~(fmask | (fmask << sw))) | (low_field << sw) | high_field;

      dec.basis   = s;
      dec.fact_re = '0;
      dec.fact_im = '0;
      dec.mul     = 1'b0;

      case (cfg.gate_op)
         qgbeu_pkg::GATE_MCNOT: begin
            if (ctl) begin
               dec.basis = flipped;
            end
         end
         qgbeu_pkg::GATE_X: begin
            dec.basis = flipped;
         end
         qgbeu_pkg::GATE_Y: begin
            dec.basis   = flipped;
            dec.mul     = 1'b1;
            dec.fact_im = (|(flipped & tmask)) ? qgbeu_pkg::FACT_ONE
                                               : qgbeu_pkg::FACT_NEG_ONE;
         end
         qgbeu_pkg::GATE_Z: begin
            if (hit) begin
               dec.mul     = 1'b1;
               dec.fact_re = qgbeu_pkg::FACT_NEG_ONE;
            end
         end
         qgbeu_pkg::GATE_ROT_Z: begin
            dec.mul     = 1'b1;
            dec.fact_re = zr;
            dec.fact_im = zi_sel;
         end
         qgbeu_pkg::GATE_PHASE_SCALE: begin
            dec.mul     = 1'b1;
            dec.fact_re = zr;
            dec.fact_im = zi;
         end
         qgbeu_pkg::GATE_PHASE_KICK: begin
            if (hit) begin
               dec.mul     = 1'b1;
               dec.fact_re = zr;
               dec.fact_im = zi;
            end
         end
         qgbeu_pkg::GATE_COND_PHASE: begin
            if (ctl && hit) begin
               dec.mul     = 1'b1;
               dec.fact_re = zr;
               dec.fact_im = zi;
            end
         end
         qgbeu_pkg::GATE_COND_SHIFT: begin
            if (ctl) begin
               dec.mul     = 1'b1;
               dec.fact_re = zr;
               dec.fact_im = zi_sel;
            end
         end
         qgbeu_pkg::GATE_SWAP: begin
            if (sw != '0) begin
               dec.basis = swapped;
            end
         end
         default: begin
            dec.basis = s;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/quantum_gate_basis_entry_update_top.sv */
// Applies one configured quantum gate to a stream of sparse-register entries
// (basis state, Q1.30 complex amplitude, last flag) and returns one updated
// entry per input. Throughput is one entry per clock while the result side
// does not stall. Each entry passes through four register stages: gate
// decode, the four 32x33 multipliers, the complex add with rounding, and
// saturation into the output register. Stalls on the result side back up
// stage by stage, so empty stages keep filling. Gate registers sit on a
// 64-bit APB port at byte addresses 8*i and must only be written while no
// entry is in flight.
`default_nettype none

`include "quantum_gate_basis_entry_update_top_macros.svh"

module quantum_gate_basis_entry_update_top (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire qgbeu_pkg::req_payload_type             req_payload,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output qgbeu_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [qgbeu_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [qgbeu_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [qgbeu_pkg::CSR_DATA_BITS-1:0]         prdata,
   output logic                                        pready
);

   localparam int AB = qgbeu_pkg::AMP_BITS;
   localparam int PB = qgbeu_pkg::PROD_BITS;
   localparam int SB = qgbeu_pkg::SUM_BITS;
   localparam int FB = qgbeu_pkg::FRAC_BITS;

   // Configuration registers.
   qgbeu_pkg::cfg_type                       cfg_ff;
   logic [qgbeu_pkg::REG_IDX_BITS-1:0]       csr_index;
   logic                                     csr_write;

   // Stage 1: decoded gate.
   qgbeu_pkg::dec_type                       dec;
   logic                                     s1_valid_ff;
   qgbeu_pkg::dec_type                       s1_dec_ff;
   logic signed [AB-1:0]                     s1_ar_ff;
   logic signed [AB-1:0]                     s1_ai_ff;
   logic                                     s1_last_ff;

   // Stage 2: partial products.
   logic                                     s2_valid_ff;
   logic [qgbeu_pkg::STATE_BITS-1:0]         s2_basis_ff;
   logic signed [AB-1:0]                     s2_ar_ff;
   logic signed [AB-1:0]                     s2_ai_ff;
   logic signed [PB-1:0]                     s2_prr_ff;
   logic signed [PB-1:0]                     s2_pii_ff;
   logic signed [PB-1:0]                     s2_pri_ff;
   logic signed [PB-1:0]                     s2_pir_ff;
   logic                                     s2_mul_ff;
   logic                                     s2_last_ff;

   // Stage 3: rounded sums.
   logic                                     s3_valid_ff;
   logic [qgbeu_pkg::STATE_BITS-1:0]         s3_basis_ff;
   logic signed [AB-1:0]                     s3_ar_ff;
   logic signed [AB-1:0]                     s3_ai_ff;
   logic signed [SB-1:0]                     s3_acc_re_ff;
   logic signed [SB-1:0]                     s3_acc_im_ff;
   logic                                     s3_mul_ff;
   logic                                     s3_last_ff;

   // Stage 4: output register.
   logic                                     s4_valid_ff;
   qgbeu_pkg::rsp_payload_type               s4_payload_ff;
   qgbeu_pkg::rsp_payload_type               s4_payload_in;

   logic                                     rdy1;
   logic                                     rdy2;
   logic                                     rdy3;
   logic                                     rdy4;

   function automatic logic signed [AB-1:0] round_sat(input logic signed [SB-1:0] acc);
      logic [SB-FB-AB:0] top_bits;
      top_bits = acc[SB-1:FB+AB-1];
      if ((&top_bits) || !(|top_bits)) begin
         return acc[FB+AB-1:FB];
      end else if (acc[SB-1]) begin
         return qgbeu_pkg::AMP_MIN;
      end else begin
         return qgbeu_pkg::AMP_MAX;
      end
   endfunction

   // ---------------------------------------------------------------- CSR
   assign pready    = 1'b1;
   assign csr_index = paddr[qgbeu_pkg::CSR_ADDR_BITS-1:qgbeu_pkg::CSR_ADDR_BITS-
                            qgbeu_pkg::REG_IDX_BITS];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_op      <= '0;
         cfg_ff.control_mask <= '0;
         cfg_ff.target_bit   <= '0;
         cfg_ff.phase_real   <= qgbeu_pkg::PHASE_ONE;
         cfg_ff.phase_imag   <= '0;
         cfg_ff.swap_width   <= qgbeu_pkg::SWW_BITS'(1);
      end else if (csr_write) begin
         case (csr_index)
            qgbeu_pkg::REG_GATE_OP:
               cfg_ff.gate_op <= pwdata[qgbeu_pkg::OP_BITS-1:0];
            qgbeu_pkg::REG_CONTROL_MASK:
               cfg_ff.control_mask <= pwdata[qgbeu_pkg::MASK_BITS-1:0];
            qgbeu_pkg::REG_TARGET_BIT:
               cfg_ff.target_bit <= pwdata[qgbeu_pkg::TGT_BITS-1:0];
            qgbeu_pkg::REG_PHASE_REAL:
               cfg_ff.phase_real <= pwdata[AB-1:0];
            qgbeu_pkg::REG_PHASE_IMAG:
               cfg_ff.phase_imag <= pwdata[AB-1:0];
            qgbeu_pkg::REG_SWAP_WIDTH:
               cfg_ff.swap_width <= pwdata[qgbeu_pkg::SWW_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         qgbeu_pkg::REG_GATE_OP:
            prdata = qgbeu_pkg::CSR_DATA_BITS'(cfg_ff.gate_op);
         qgbeu_pkg::REG_CONTROL_MASK:
            prdata = qgbeu_pkg::CSR_DATA_BITS'(cfg_ff.control_mask);
         qgbeu_pkg::REG_TARGET_BIT:
            prdata = qgbeu_pkg::CSR_DATA_BITS'(cfg_ff.target_bit);
         qgbeu_pkg::REG_PHASE_REAL:
            prdata = qgbeu_pkg::CSR_DATA_BITS'($unsigned(cfg_ff.phase_real));
         qgbeu_pkg::REG_PHASE_IMAG:
            prdata = qgbeu_pkg::CSR_DATA_BITS'($unsigned(cfg_ff.phase_imag));
         qgbeu_pkg::REG_SWAP_WIDTH:
            prdata = qgbeu_pkg::CSR_DATA_BITS'(cfg_ff.swap_width);
         default:
            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- pipeline
   // Each stage loads whenever it is empty or its contents move on.
   assign rdy4      = !s4_valid_ff || rsp_ready;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_ready = rdy1;

   qgbeu_gate_decode u_decode (
      .basis_in (req_payload.basis_in),
      .cfg      (cfg_ff),
      .dec      (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff <= req_valid;
         if (rdy2) s2_valid_ff <= s1_valid_ff;
         if (rdy3) s3_valid_ff <= s2_valid_ff;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         s1_dec_ff  <= dec;
         s1_ar_ff   <= AB'(req_payload.amp_re_in);
         s1_ai_ff   <= AB'(req_payload.amp_im_in);
         s1_last_ff <= req_payload.last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && s1_valid_ff) begin
         s2_basis_ff <= s1_dec_ff.basis;
         s2_ar_ff    <= s1_ar_ff;
         s2_ai_ff    <= s1_ai_ff;
         s2_prr_ff   <= PB'(s1_ar_ff) * PB'(s1_dec_ff.fact_re);
         s2_pii_ff   <= PB'(s1_ai_ff) * PB'(s1_dec_ff.fact_im);
         s2_pri_ff   <= PB'(s1_ar_ff) * PB'(s1_dec_ff.fact_im);
         s2_pir_ff   <= PB'(s1_ai_ff) * PB'(s1_dec_ff.fact_re);
         s2_mul_ff   <= s1_dec_ff.mul;
         s2_last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && s2_valid_ff) begin
         s3_basis_ff  <= s2_basis_ff;
         s3_ar_ff     <= s2_ar_ff;
         s3_ai_ff     <= s2_ai_ff;
         s3_acc_re_ff <= SB'(s2_prr_ff) - SB'(s2_pii_ff) + qgbeu_pkg::ROUND_HALF;
         s3_acc_im_ff <= SB'(s2_pri_ff) + SB'(s2_pir_ff) + qgbeu_pkg::ROUND_HALF;
         s3_mul_ff    <= s2_mul_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   always_comb begin
      s4_payload_in.basis_out = 64'(s3_basis_ff);
      s4_payload_in.last_out  = s3_last_ff;
      if (s3_mul_ff) begin
         s4_payload_in.amp_re_out = 32'(round_sat(s3_acc_re_ff));
         s4_payload_in.amp_im_out = 32'(round_sat(s3_acc_im_ff));
      end else begin
         s4_payload_in.amp_re_out = 32'(s3_ar_ff);
         s4_payload_in.amp_im_out = 32'(s3_ai_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && s3_valid_ff) begin
         s4_payload_ff <= s4_payload_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_payload = s4_payload_ff;

   // ---------------------------------------------------------- checks
   `QGBEU_ASSERT_SAME(a_empty_out_takes_input, clock, reset,
      !rsp_valid, req_ready, "input stalled while the output stage is empty")
   `QGBEU_ASSERT_NEXT(a_plain_keeps_re, clock, reset,
      s3_valid_ff && rdy4 && !s3_mul_ff, rsp_payload.amp_re_out == 32'($past(s3_ar_ff)),
      "real amplitude changed by a gate that does not multiply")
   `QGBEU_ASSERT_NEXT(a_plain_keeps_im, clock, reset,
      s3_valid_ff && rdy4 && !s3_mul_ff, rsp_payload.amp_im_out == 32'($past(s3_ai_ff)),
      "imaginary amplitude changed by a gate that does not multiply")

endmodule

`default_nettype wire
